/* rtl/core/huffman_code_builder_unit_assert.svh */
// Assertion macros shared by the checker of the Huffman code builder.
`ifndef HUFFMAN_CODE_BUILDER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HCB_ASSERT_IMPLY(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("huffman_code_builder_unit: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HCB_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("huffman_code_builder_unit: next-cycle check failed");

`endif

/* rtl/core/huf_pkg.sv */
// Shared command codes and controller/datapath interface types.
`default_nettype none
package huf_pkg;

	localparam int OP_W = 4;

	localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
	localparam logic [OP_W-1:0] OP_READ   = 4'd2;
	localparam logic [OP_W-1:0] OP_SINGLE = 4'd3;
	localparam logic [OP_W-1:0] OP_MINIT  = 4'd4;
	localparam logic [OP_W-1:0] OP_SCAN   = 4'd5;
	localparam logic [OP_W-1:0] OP_MRG1   = 4'd6;
	localparam logic [OP_W-1:0] OP_MRG2   = 4'd7;
	localparam logic [OP_W-1:0] OP_MRG3   = 4'd8;
	localparam logic [OP_W-1:0] OP_WINIT  = 4'd9;
	localparam logic [OP_W-1:0] OP_WCHK   = 4'd10;
	localparam logic [OP_W-1:0] OP_WLC    = 4'd11;
	localparam logic [OP_W-1:0] OP_WWR    = 4'd12;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic merge_last;
		logic p_root;
		logic d_over;
		logic leaf_last;
		logic n_one;
	} status_t;

endpackage
`default_nettype wire

/* rtl/core/huffman_code_builder_unit.sv */
// Huffman code builder: load items fill the leaf stores, the last one builds the codes.
// Load item: busy stays low unless last_item is set. Read item: result in the next cycle.
// Build: n-1 merges, each a scan with one parent/weight read per node on the scan port, then
// the merge writes; the code walk then climbs one parent per code bit and writes each leaf's code.
// The receiver cannot stall; done marks a result for one cycle.
// arst_n clears the symbol count, the built flag and the controller; tree stores are not cleared.
`default_nettype none
module huffman_code_builder_unit #(
	parameter int MAX_SYMBOLS   = 256,
	parameter int WEIGHT_BITS   = 24,
	parameter int MAX_CODE_BITS = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     action,
	input  wire logic [7:0]               symbol,
	input  wire logic [23:0]              weight,
	input  wire logic                     last_item,
	input  wire logic [7:0]               entry_index,
	output logic                          done,
	output logic [7:0]                    out_symbol,
	output logic [MAX_CODE_BITS-1:0]      code_bits,
	output logic [5:0]                    code_length,
	output logic                          in_range
);
	import huf_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    start_ok;

	assign start_ok = start && !busy;

	huf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_ok),
		.action    (action),
		.last_item (last_item),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	huf_dp #(
		.MAX_SYMBOLS   (MAX_SYMBOLS),
		.WEIGHT_BITS   (WEIGHT_BITS),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.symbol      (symbol),
		.weight      (weight),
		.entry_index (entry_index),
		.status      (status),
		.done        (done),
		.out_symbol  (out_symbol),
		.code_bits   (code_bits),
		.code_length (code_length),
		.in_range    (in_range)
	);

endmodule
`default_nettype wire

/* rtl/core/huf_ctrl.sv */
// Controller state machine that sequences load, read, merge and code walk.
`default_nettype none
module huf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           action,
	input  wire logic           last_item,
	input  huf_pkg::status_t    status,
	output huf_pkg::cmd_t       cmd,
	output logic                busy
);
	import huf_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BCHK  = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_MRG2  = 4'd3;
	localparam logic [3:0] S_MRG3  = 4'd4;
	localparam logic [3:0] S_WINIT = 4'd5;
	localparam logic [3:0] S_WCHK  = 4'd6;
	localparam logic [3:0] S_WLC   = 4'd7;
	localparam logic [3:0] S_WWR   = 4'd8;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (action) begin
						cmd.op = OP_READ;
					end else begin
						cmd.op = OP_LOAD;
						if (last_item) state_d = S_BCHK;
					end
				end
			end
			S_BCHK: begin
				if (status.n_one) begin
					cmd.op = OP_SINGLE;
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_MINIT;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// The final compare lands before scan_done rises, so the merge can start here.
				if (status.scan_done) begin
					cmd.op = OP_MRG1;
					state_d = S_MRG2;
				end else begin
					cmd.op = OP_SCAN;
				end
			end
			S_MRG2: begin
				cmd.op = OP_MRG2;
				state_d = S_MRG3;
			end
			S_MRG3: begin
				cmd.op = OP_MRG3;
				state_d = status.merge_last ? S_WINIT : S_SCAN;
			end
			S_WINIT: begin
				cmd.op = OP_WINIT;
				state_d = S_WCHK;
			end
			S_WCHK: begin
				cmd.op = OP_WCHK;
				state_d = (status.p_root || status.d_over) ? S_WWR : S_WLC;
			end
			S_WLC: begin
				cmd.op = OP_WLC;
				state_d = S_WCHK;
			end
			S_WWR: begin
				cmd.op = OP_WWR;
				state_d = status.leaf_last ? S_IDLE : S_WCHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* rtl/core/huf_dp.sv */
// Datapath: symbol, tree and code memories with the scan and walk registers.
`default_nettype none
module huf_dp #(
	parameter int MAX_SYMBOLS   = 256,
	parameter int WEIGHT_BITS   = 24,
	parameter int MAX_CODE_BITS = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  huf_pkg::cmd_t                 cmd,
	input  wire logic [7:0]               symbol,
	input  wire logic [23:0]              weight,
	input  wire logic [7:0]               entry_index,
	output huf_pkg::status_t              status,
	output logic                          done,
	output logic [7:0]                    out_symbol,
	output logic [MAX_CODE_BITS-1:0]      code_bits,
	output logic [5:0]                    code_length,
	output logic                          in_range
);
	import huf_pkg::*;

	localparam int SAW        = $clog2(MAX_SYMBOLS);
	localparam int CW         = $clog2(MAX_SYMBOLS + 1);
	localparam int NODES      = 2 * MAX_SYMBOLS - 1;
	localparam int NAW        = $clog2(NODES);
	localparam int PW         = $clog2(2 * MAX_SYMBOLS);
	localparam int WW         = WEIGHT_BITS + SAW;
	localparam int CODE_LIMIT = (MAX_CODE_BITS < 63) ? MAX_CODE_BITS : 63;
	localparam int DIW        = $clog2(MAX_CODE_BITS);

	logic [7:0]               sym_mem  [MAX_SYMBOLS];
	logic [WW-1:0]            wt_mem   [NODES];
	logic [PW-1:0]            par_mem  [NODES];
	logic [NAW-1:0]           lc_mem   [MAX_SYMBOLS-1];
	logic [MAX_CODE_BITS-1:0] code_mem [MAX_SYMBOLS];
	logic [5:0]               len_mem  [MAX_SYMBOLS];

	logic [CW-1:0]            count_q;
	logic                     built_q;
	logic [NAW-1:0]           k_q, i_q, idx_s1, a_q, b_q, c_q;
	logic                     pend_s1, a_vld_q, b_vld_q;
	logic [WW-1:0]            wa_q, wb_q, wt_rd_q;
	logic [PW-1:0]            par_rd_q;
	logic [NAW-1:0]           lc_rd_q;
	logic [SAW-1:0]           leaf_q;
	logic [5:0]               dep_q;
	logic [MAX_CODE_BITS-1:0] code_q;
	logic                     over_q;
	logic [7:0]               sym_rd_q;
	logic [MAX_CODE_BITS-1:0] code_rd_q;
	logic [5:0]               len_rd_q;
	logic                     done_q, in_range_q;

	logic [CW-1:0]            lidx;
	logic                     ld_we;
	logic [NAW-1:0]           n_node, f_node;
	logic [NAW:0]             n2;
	logic                     scan_issue;
	logic [PW-1:0]            kp1;

	logic                     par_we, par_re;
	logic [NAW-1:0]           par_waddr, par_raddr;
	logic [PW-1:0]            par_wdata;

	logic                     cd_we;
	logic [SAW-1:0]           cd_waddr;
	logic [MAX_CODE_BITS-1:0] cd_wcode;
	logic [5:0]               cd_wlen;

	assign lidx       = built_q ? '0 : count_q;
	assign ld_we      = built_q || (count_q != CW'(MAX_SYMBOLS));
	assign n_node     = NAW'(count_q);
	assign n2         = {n_node, 1'b0} - (NAW + 1)'(2);
	assign f_node     = NAW'(par_rd_q - PW'(1));
	assign scan_issue = (cmd.op == OP_SCAN) && (i_q < k_q);
	assign kp1        = PW'(k_q) + PW'(1);

	assign status.scan_done  = (i_q == k_q) && !pend_s1;
	assign status.merge_last = (k_q == NAW'(n2));
	assign status.p_root     = (par_rd_q == '0);
	assign status.d_over     = (dep_q >= 6'(CODE_LIMIT));
	assign status.leaf_last  = (leaf_q == SAW'(count_q - CW'(1)));
	assign status.n_one      = (count_q == CW'(1));

	// Parent store port selection.
	always_comb begin
		par_we = 1'b0;
		par_waddr = '0;
		par_wdata = '0;
		par_re = 1'b0;
		par_raddr = '0;
		case (cmd.op)
			OP_LOAD: begin
				par_we = ld_we;
				par_waddr = NAW'(lidx);
			end
			OP_MRG1: begin
				par_we = 1'b1;
				par_waddr = a_q;
				par_wdata = kp1;
			end
			OP_MRG2: begin
				par_we = 1'b1;
				par_waddr = b_q;
				par_wdata = kp1;
			end
			OP_MRG3: begin
				par_we = 1'b1;
				par_waddr = k_q;
			end
			OP_SCAN: begin
				par_re = scan_issue;
				par_raddr = i_q;
			end
			OP_WINIT: begin
				par_re = 1'b1;
			end
			OP_WLC: begin
				par_re = 1'b1;
				par_raddr = f_node;
			end
			OP_WWR: begin
				par_re = 1'b1;
				par_raddr = NAW'(leaf_q) + NAW'(1);
			end
			default: begin
			end
		endcase
	end

	// Code and length store port selection.
	always_comb begin
		cd_we = 1'b0;
		cd_waddr = '0;
		cd_wcode = '0;
		cd_wlen = '0;
		case (cmd.op)
			OP_LOAD: begin
				cd_we = ld_we;
				cd_waddr = SAW'(lidx);
			end
			OP_SINGLE: begin
				cd_we = 1'b1;
				cd_wlen = 6'd1;
			end
			OP_WWR: begin
				cd_we = 1'b1;
				cd_waddr = leaf_q;
				cd_wcode = over_q ? '0 : code_q;
				cd_wlen = over_q ? 6'd0 : dep_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_waddr] <= par_wdata;
		if (par_re) par_rd_q <= par_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && ld_we) wt_mem[NAW'(lidx)] <= WW'(weight[WEIGHT_BITS-1:0]);
		else if (cmd.op == OP_MRG1) wt_mem[k_q] <= wa_q + wb_q;
		if (scan_issue) wt_rd_q <= wt_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MRG1) lc_mem[SAW'(k_q - n_node)] <= a_q;
		if (cmd.op == OP_WCHK) lc_rd_q <= lc_mem[SAW'(f_node - n_node)];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && ld_we) sym_mem[SAW'(lidx)] <= symbol;
		if (cd_we) begin
			code_mem[cd_waddr] <= cd_wcode;
			len_mem[cd_waddr] <= cd_wlen;
		end
		if (cmd.op == OP_READ) begin
			sym_rd_q <= sym_mem[SAW'(entry_index)];
			code_rd_q <= code_mem[SAW'(entry_index)];
			len_rd_q <= len_mem[SAW'(entry_index)];
		end
	end

	always_ff @(posedge clk) begin
		// Strict compares over ascending indices keep ties on the lower node.
		if (pend_s1 && par_rd_q == '0) begin
			if (!a_vld_q || wt_rd_q < wa_q) begin
				b_q <= a_q;
				wb_q <= wa_q;
				a_q <= idx_s1;
				wa_q <= wt_rd_q;
			end else if (!b_vld_q || wt_rd_q < wb_q) begin
				b_q <= idx_s1;
				wb_q <= wt_rd_q;
			end
		end
		if (scan_issue) idx_s1 <= i_q;
		case (cmd.op)
			OP_WINIT: begin
				code_q <= '0;
			end
			OP_WLC: begin
				if (lc_rd_q != c_q) code_q[dep_q[DIW-1:0]] <= 1'b1;
			end
			OP_WWR: begin
				code_q <= '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			built_q <= 1'b0;
			k_q <= '0;
			i_q <= '0;
			pend_s1 <= 1'b0;
			a_vld_q <= 1'b0;
			b_vld_q <= 1'b0;
			leaf_q <= '0;
			c_q <= '0;
			dep_q <= '0;
			over_q <= 1'b0;
			done_q <= 1'b0;
			in_range_q <= 1'b0;
		end else begin
			pend_s1 <= scan_issue;
			done_q <= (cmd.op == OP_READ);
			if (cmd.op == OP_READ) in_range_q <= ({1'b0, entry_index} < 9'(count_q));
			if (pend_s1 && par_rd_q == '0) begin
				if (!a_vld_q || wt_rd_q < wa_q) begin
					a_vld_q <= 1'b1;
					b_vld_q <= a_vld_q;
				end else if (!b_vld_q || wt_rd_q < wb_q) begin
					b_vld_q <= 1'b1;
				end
			end
			case (cmd.op)
				OP_LOAD: begin
					if (built_q) begin
						built_q <= 1'b0;
						count_q <= CW'(1);
					end else if (ld_we) begin
						count_q <= count_q + CW'(1);
					end
				end
				OP_SINGLE: begin
					built_q <= 1'b1;
				end
				OP_MINIT: begin
					k_q <= n_node;
					i_q <= '0;
					a_vld_q <= 1'b0;
					b_vld_q <= 1'b0;
				end
				OP_SCAN: begin
					if (scan_issue) i_q <= i_q + NAW'(1);
				end
				OP_MRG3: begin
					k_q <= k_q + NAW'(1);
					i_q <= '0;
					a_vld_q <= 1'b0;
					b_vld_q <= 1'b0;
				end
				OP_WINIT: begin
					leaf_q <= '0;
					c_q <= '0;
					dep_q <= '0;
					over_q <= 1'b0;
				end
				OP_WCHK: begin
					over_q <= !status.p_root && status.d_over;
				end
				OP_WLC: begin
					c_q <= f_node;
					dep_q <= dep_q + 6'd1;
				end
				OP_WWR: begin
					if (status.leaf_last) built_q <= 1'b1;
					leaf_q <= leaf_q + SAW'(1);
					c_q <= NAW'(leaf_q) + NAW'(1);
					dep_q <= '0;
					over_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign done        = done_q;
	assign out_symbol  = in_range_q ? sym_rd_q : 8'd0;
	assign code_bits   = in_range_q ? code_rd_q : '0;
	assign code_length = in_range_q ? len_rd_q : 6'd0;
	assign in_range    = in_range_q;

endmodule
`default_nettype wire

/* rtl/core/huffman_code_builder_unit_chk.sv */
// Port-level checker for the Huffman code builder and its bind to the top level.
`default_nettype none
`include "huffman_code_builder_unit_assert.svh"
module huffman_code_builder_unit_chk #(
	parameter int MAX_CODE_BITS = 64
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic                     action,
	input wire logic                     last_item,
	input wire logic                     done,
	input wire logic [7:0]               out_symbol,
	input wire logic [MAX_CODE_BITS-1:0] code_bits,
	input wire logic [5:0]               code_length,
	input wire logic                     in_range
);

	// A read item gives its result in the next cycle; a load item gives none.
	`HCB_ASSERT_NEXT(a_read_result, start && !busy && action, done)
	`HCB_ASSERT_NEXT(a_load_silent, start && !busy && !action, !done)
	// A load item that is not the last one leaves the block free for the next item.
	`HCB_ASSERT_NEXT(a_load_free, start && !busy && !action && !last_item, !busy)
	// No result can come out while a build runs.
	`HCB_ASSERT_IMPLY(a_busy_quiet, busy, !done)
	// An entry past the loaded count reads as all zero.
	`HCB_ASSERT_IMPLY(a_out_of_range, done && !in_range,
		out_symbol == 8'd0 && code_bits == '0 && code_length == 6'd0)

endmodule

bind huffman_code_builder_unit huffman_code_builder_unit_chk #(
	.MAX_CODE_BITS (MAX_CODE_BITS)
) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.action      (action),
	.last_item   (last_item),
	.done        (done),
	.out_symbol  (out_symbol),
	.code_bits   (code_bits),
	.code_length (code_length),
	.in_range    (in_range)
);
`default_nettype wire

/* tb/sv/huffman_code_builder_unit_tb.sv */
// Self-checking testbench of the Huffman code builder: random loads, builds and code reads.
`timescale 1ns / 1ps
`default_nettype none
module huffman_code_builder_unit_tb;

	localparam int NSYM = 256;
	localparam int NODES = 2 * NSYM - 1;
	localparam int CODE_LIMIT = 63;
	localparam int WD_LIMIT = 1000000;
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct {
		logic [7:0]  sym;
		logic [63:0] code;
		logic [5:0]  len;
		logic        inr;
	} code_entry_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [7:0]  symbol;
	logic [23:0] weight;
	logic        last_item;
	logic [7:0]  entry_index;
	logic        done;
	logic [7:0]  out_symbol;
	logic [63:0] code_bits;
	logic [5:0]  code_length;
	logic        in_range;

	code_entry_t pending_codes[$];
	int          fail_count;
	int          idle_cycles;
	int          items_sent;

	// Own copy of the builder state.
	int          sym_count;
	bit          tree_built;
	bit [7:0]    leaf_sym[NSYM];
	bit [31:0]   node_w[NODES];
	bit [9:0]    node_up[NODES];
	int          left_of[NSYM-1];
	bit [63:0]   leaf_code[NSYM];
	bit [5:0]    leaf_len[NSYM];

	huffman_code_builder_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.symbol(symbol), .weight(weight), .last_item(last_item),
		.entry_index(entry_index), .done(done), .out_symbol(out_symbol),
		.code_bits(code_bits), .code_length(code_length), .in_range(in_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void build_codes();
		int n, k, i, a, b, c, f, depth;
		bit [63:0] cw;
		bit over;
		n = sym_count;
		tree_built = 1'b1;
		if (n == 0)
			return;
		if (n == 1) begin
			leaf_code[0] = '0;
			leaf_len[0] = 6'd1;
			return;
		end
		for (i = 0; i < n; i++)
			node_up[i] = '0;
		for (k = n; k < 2 * n - 1; k++) begin
			a = NODES;
			b = NODES;
			for (i = 0; i < k; i++)
				if (node_up[i] == 0 && (a == NODES || node_w[i] < node_w[a]))
					a = i;
			for (i = 0; i < k; i++)
				if (node_up[i] == 0 && i != a && (b == NODES || node_w[i] < node_w[b]))
					b = i;
			if (a >= NODES || b >= NODES)
				return;
			node_up[a] = k + 1;
			node_up[b] = k + 1;
			left_of[k - n] = a;
			node_w[k] = node_w[a] + node_w[b];
			node_up[k] = '0;
		end
		for (i = 0; i < n; i++) begin
			c = i;
			depth = 0;
			cw = '0;
			over = 1'b0;
			while (c < NODES && node_up[c] != 0) begin
				f = node_up[c] - 1;
				if (f < n || f >= 2 * n - 1)
					break;
				if (depth >= CODE_LIMIT) begin
					over = 1'b1;
					break;
				end
				if (left_of[f - n] != c)
					cw[depth] = 1'b1;
				depth++;
				c = f;
			end
			leaf_code[i] = over ? '0 : cw;
			leaf_len[i] = over ? 6'd0 : 6'(depth);
		end
	endfunction

	function automatic void predict_item(logic act, logic [7:0] sy, logic [23:0] w,
			logic lst, logic [7:0] idx);
		code_entry_t e;
		if (act == ACT_LOAD) begin
			if (tree_built) begin
				tree_built = 1'b0;
				sym_count = 0;
			end
			if (sym_count < NSYM) begin
				leaf_sym[sym_count] = sy;
				node_w[sym_count] = {8'd0, w};
				node_up[sym_count] = '0;
				leaf_code[sym_count] = '0;
				leaf_len[sym_count] = '0;
				sym_count++;
			end
			if (lst)
				build_codes();
		end else begin
			if (idx < sym_count) begin
				e.sym = leaf_sym[idx];
				e.code = leaf_code[idx];
				e.len = leaf_len[idx];
				e.inr = 1'b1;
			end else begin
				e.sym = '0;
				e.code = '0;
				e.len = '0;
				e.inr = 1'b0;
			end
			pending_codes.push_back(e);
		end
	endfunction

	// Sends one item after a random gap and returns once it has been accepted.
	task automatic send_item(logic act, logic [7:0] sy, logic [23:0] w, logic lst,
			logic [7:0] idx);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		if ($urandom_range(0, 9) < 4)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= act;
		symbol <= sy;
		weight <= w;
		last_item <= lst;
		entry_index <= idx;
		start <= 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		predict_item(act, sy, w, lst, idx);
		items_sent++;
	endtask

	task automatic load_sym(logic [7:0] sy, logic [23:0] w, logic lst);
		send_item(ACT_LOAD, sy, w, lst, 8'($urandom));
	endtask

	task automatic read_entry(logic [7:0] idx);
		send_item(ACT_READ, 8'($urandom), 24'($urandom), 1'($urandom), idx);
	endtask

	task automatic read_all(int n);
		for (int i = 0; i < n; i++)
			read_entry(8'(i));
	endtask

	function automatic logic [23:0] rand_weight();
		logic [23:0] w;
		case ($urandom_range(0, 3))
			0: w = 24'($urandom_range(1, 8));
			1: w = 24'($urandom) >> $urandom_range(0, 23);
			2: w = 24'hFFFFFF - 24'($urandom_range(0, 3));
			default: w = 24'($urandom);
		endcase
		return (w == 0) ? 24'd1 : w;
	endfunction

	task automatic test_reads_after_reset();
		read_entry(8'd0);
		read_entry(8'd255);
	endtask

	task automatic test_single_symbol();
		load_sym(8'hFF, 24'hFFFFFF, 1'b1);
		read_entry(8'd0);
		read_entry(8'd1);
	endtask

	task automatic test_extremes_and_ties();
		// Reads before the build see the symbols with empty codes.
		load_sym(8'h00, 24'd1, 1'b0);
		load_sym(8'hFF, 24'hFFFFFF, 1'b0);
		read_entry(8'd1);
		load_sym(8'h55, 24'd1, 1'b0);
		load_sym(8'hAA, 24'd1, 1'b1);
		read_all(4);
		read_entry(8'd200);
		load_sym(8'h12, 24'd7, 1'b0);
		load_sym(8'h34, 24'd7, 1'b0);
		load_sym(8'h56, 24'd7, 1'b1);
		read_all(3);
	endtask

	task automatic test_full_capacity();
		for (int i = 0; i < NSYM + 2; i++)
			load_sym(8'($urandom), rand_weight(), i == NSYM + 1);
		for (int i = 0; i < 20; i++)
			read_entry(8'($urandom));
		read_entry(8'd255);
	endtask

	task automatic test_random_sets(int goal);
		int n, nreads;
		while (items_sent < goal) begin
			if ($urandom_range(0, 9) == 0) begin
				read_entry(8'($urandom));
				continue;
			end
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				load_sym(8'($urandom), rand_weight(), i == n - 1);
				if ($urandom_range(0, 15) == 0)
					read_entry(8'($urandom_range(0, i + 1)));
			end
			nreads = $urandom_range(1, n + 2);
			for (int i = 0; i < nreads; i++)
				read_entry(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, n)));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_codes.size() == 0) begin
				$error("code read result with nothing expected");
				fail_count++;
			end else begin
				code_entry_t e;
				e = pending_codes.pop_front();
				if (out_symbol !== e.sym) begin
					$error("out_symbol: expected %0h, got %0h", e.sym, out_symbol);
					fail_count++;
				end
				if (code_bits !== e.code) begin
					$error("code_bits: expected %0h, got %0h", e.code, code_bits);
					fail_count++;
				end
				if (code_length !== e.len) begin
					$error("code_length: expected %0d, got %0d", e.len, code_length);
					fail_count++;
				end
				if (in_range !== e.inr) begin
					$error("in_range: expected %0b, got %0b", e.inr, in_range);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		items_sent = 0;
		sym_count = 0;
		tree_built = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_LOAD;
		symbol = '0;
		weight = 24'd1;
		last_item = 1'b0;
		entry_index = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reads_after_reset();
		test_single_symbol();
		test_extremes_and_ties();
		test_full_capacity();
		test_random_sets(1050);
		start <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_codes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
